// File: hdl/hash_counter_keystream_encryptor_core_assert.svh
// assertion macros shared by the rtl files
`ifndef HASH_COUNTER_KEYSTREAM_ENCRYPTOR_CORE_ASSERT_SVH
`define HASH_COUNTER_KEYSTREAM_ENCRYPTOR_CORE_ASSERT_SVH

// a condition implies a consequence in the same cycle
`define HCK_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// a condition implies a consequence in the next cycle
`define HCK_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/hck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hck_pkg;

   localparam int unsigned COUNTER_MAX = 32'h7fff_ffff;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIGIT,
      ST_BUILD,
      ST_ROUND,
      ST_ADD,
      ST_HDR,
      ST_DATA,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start_chunk;
      logic digit_step;
      logic build;
      logic round;
      logic add;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic digits_done;
      logic round_last;
      logic block_last;
   } status_type;

   typedef logic [31:0] word_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
         32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
         32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
         32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
         32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
         32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
         32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
         32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
         32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
         32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
         32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
            32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [7:0] mark_byte(input logic [3:0] i);
      logic [7:0] m [16];
      m = '{8'h42,8'h61,8'h73,8'h65,8'h53,8'h68,8'h69,8'h66,
            8'h74,8'h45,8'h6e,8'h63,8'h6f,8'h64,8'h65,8'h64};
      return m[i];
   endfunction

endpackage
`default_nettype wire

// File: hdl/hck_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hash_counter_keystream_encryptor_core_assert.svh"
module hck_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             op,
   input  wire logic             need_chunk,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  hdr_mode,
   output logic [4:0]            out_idx,
   input  wire hck_pkg::status_type sts,
   output hck_pkg::cmd_type      cmd
);
   hck_pkg::state_type state_ff, state_in;
   logic hdr_ff, hdr_in;
   logic [4:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hck_pkg::ST_IDLE;
         hdr_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hdr_ff   <= hdr_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      hdr_in     = hdr_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         hck_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               hdr_in = !op;
               idx_in = '0;
               if (!op || need_chunk) begin
                  cmd.start_chunk = 1'b1;
                  state_in = hck_pkg::ST_DIGIT;
               end else begin
                  cmd.out_load = 1'b1;
                  state_in = hck_pkg::ST_OUT;
               end
            end
         end
         hck_pkg::ST_DIGIT: begin
            cmd.digit_step = 1'b1;
            if (sts.digits_done) state_in = hck_pkg::ST_BUILD;
         end
         hck_pkg::ST_BUILD: begin
            cmd.build = 1'b1;
            state_in = hck_pkg::ST_ROUND;
         end
         hck_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) state_in = hck_pkg::ST_ADD;
         end
         hck_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            if (sts.block_last) state_in = hck_pkg::ST_LOAD;
            else state_in = hck_pkg::ST_BUILD;
         end
         hck_pkg::ST_LOAD: begin
            cmd.out_load = 1'b1;
            state_in = hck_pkg::ST_OUT;
         end
         hck_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (!hdr_ff || idx_ff == 5'd31) begin
                  state_in = hck_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         default: state_in = hck_pkg::ST_IDLE;
      endcase
   end

   assign hdr_mode = hdr_ff;
   assign out_idx  = idx_ff;

   `HCK_ASSERT_IMP(a_ready_idle, clock, reset, req_tready,
      state_ff == hck_pkg::ST_IDLE, "ready outside idle")
   `HCK_ASSERT_IMP(a_valid_out, clock, reset, rsp_tvalid,
      state_ff == hck_pkg::ST_OUT, "valid outside output state")
   `HCK_ASSERT_NEXT(a_start_hash, clock, reset, cmd.start_chunk,
      state_ff == hck_pkg::ST_DIGIT, "chunk start did not enter digit state")
endmodule
`default_nettype wire

// File: hdl/hck_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hash_counter_keystream_encryptor_core_assert.svh"
module hck_dp #(
   parameter int unsigned KEY_BYTES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [255:0]      key,
   input  wire logic [5:0]        key_length,
   input  wire logic [127:0]      seed,
   input  wire logic              req_accept,
   input  wire logic              op,
   input  wire logic [7:0]        plain_byte,
   input  wire logic              hdr_mode,
   input  wire logic [4:0]        out_idx,
   input  wire hck_pkg::cmd_type  cmd,
   output hck_pkg::status_type    sts,
   output logic                   need_chunk,
   output logic [7:0]             out_byte
);
   logic [30:0]  chunk_ff, chunk_in;
   logic [5:0]   pos_ff;
   logic [255:0] ks_ff;
   logic [7:0]   plain_ff;
   logic [7:0]   out_ff;
   logic [30:0]  num_ff;
   logic [79:0]  dig_ff;
   logic [3:0]   nd_ff;
   logic [5:0]   len_ff;
   logic         blk_ff;
   logic         nblk_ff;
   logic [5:0]   rnd_ff;
   logic [255:0] h_ff;
   logic [31:0]  v_ff [8];
   logic [31:0]  w_ff [16];
   logic [5:0]   klen;
   logic [1023:0] msg;
   logic [10:0]  bits;
   logic [30:0]  q;
   logic [3:0]   r;
   logic [31:0]  t1, t2, s0, s1, wn;
   logic [7:0]   ks_byte;
   logic [4:0]   ks_idx;

   assign klen = (key_length > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : key_length;
   assign q = 31'((64'(num_ff) * 64'h0000_0000_cccc_cccd) >> 35);
   assign r = 4'(num_ff - 31'(q * 31'd10));

   always_comb begin
      msg = '0;
      for (int i = 0; i < 32; i++)
         if (6'(i) < klen) msg[1023 - 8*i -: 8] = key[255 - 8*i -: 8];
      for (int i = 0; i < 16; i++)
         msg[1023 - 8*(i + 32'(klen)) -: 8] = seed[127 - 8*i -: 8];
      msg[1023 - 8*(16 + 32'(klen)) -: 8] = 8'd58;
      for (int i = 0; i < 10; i++)
         if (4'(i) < nd_ff)
            msg[1023 - 8*(17 + 32'(klen) + i) -: 8] = dig_ff[8*i +: 8];
      msg[1023 - 8*(32'(len_ff)) -: 8] = 8'h80;
      bits = 11'({len_ff, 3'b000});
      if (len_ff > 6'd55) msg[10:0] = bits;
      else msg[522:512] = bits;
   end

   always_comb begin
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
         ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + ({v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
         ^ {v_ff[4][24:0], v_ff[4][31:25]}) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + hck_pkg::round_k(rnd_ff) + w_ff[0];
      t2 = ({v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
         ^ {v_ff[0][21:0], v_ff[0][31:22]})
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign chunk_in = (chunk_ff < 31'(hck_pkg::COUNTER_MAX)) ? chunk_ff + 31'd1 : chunk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= '0;
         pos_ff   <= 6'd32;
         ks_ff    <= '0;
      end else begin
         if (req_accept && !op) begin
            chunk_ff <= 31'd1;
         end else if (req_accept && pos_ff[5]) begin
            chunk_ff <= chunk_in;
         end
         if (req_accept) begin
            if (!op) pos_ff <= 6'd32;
            else pos_ff <= pos_ff[5] ? 6'd1 : pos_ff + 6'd1;
         end
         if (cmd.add && blk_ff == nblk_ff) begin
            for (int i = 0; i < 8; i++)
               ks_ff[255 - 32*i -: 32] <= h_ff[255 - 32*i -: 32] + v_ff[i];
         end
      end
   end

   assign ks_idx  = hdr_mode ? {1'b0, out_idx[3:0]} : 5'(pos_ff - 6'd1);
   assign ks_byte = ks_ff[255 - 8*ks_idx -: 8];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         plain_ff <= plain_byte;
         num_ff   <= op ? chunk_ff : 31'd0;
         nd_ff    <= '0;
      end
      if (cmd.digit_step) begin
         dig_ff <= {dig_ff[71:0], 4'h3, r};
         nd_ff  <= nd_ff + 4'd1;
         num_ff <= q;
      end
      if (sts.digits_done && cmd.digit_step) begin
         len_ff  <= klen + 6'd18 + 6'(nd_ff);
         blk_ff  <= 1'b0;
         nblk_ff <= ((klen + 6'd18 + 6'(nd_ff)) > 6'd55) ? 1'b1 : 1'b0;
         for (int i = 0; i < 8; i++) h_ff[255 - 32*i -: 32] <= hck_pkg::init_h(3'(i));
      end
      if (cmd.build) begin
         for (int i = 0; i < 16; i++)
            w_ff[i] <= blk_ff ? msg[511 - 32*i -: 32] : msg[1023 - 32*i -: 32];
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[255 - 32*i -: 32];
         rnd_ff <= '0;
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wn;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         rnd_ff <= rnd_ff + 6'd1;
      end
      if (cmd.add) begin
         for (int i = 0; i < 8; i++)
            h_ff[255 - 32*i -: 32] <= h_ff[255 - 32*i -: 32] + v_ff[i];
         blk_ff <= 1'b1;
      end
      if (cmd.out_load) out_ff <= req_accept ? plain_byte : plain_ff;
   end

   always_comb begin
      if (hdr_mode) begin
         if (!out_idx[4]) out_byte = seed[127 - 8*out_idx[3:0] -: 8];
         else out_byte = hck_pkg::mark_byte(out_idx[3:0]) + ks_byte;
      end else begin
         out_byte = out_ff + ks_byte;
      end
   end

   assign sts.digits_done = (q == 31'd0) || (nd_ff == 4'd9);
   assign sts.round_last  = (rnd_ff == 6'd63);
   assign sts.block_last  = (blk_ff == nblk_ff);
   assign need_chunk      = pos_ff[5];

   `HCK_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= 6'd32, "position out of range")
   `HCK_ASSERT_IMP(a_chunk_max, clock, reset, 1'b1,
      chunk_ff <= 31'(hck_pkg::COUNTER_MAX), "chunk counter overflow")
   `HCK_ASSERT_NEXT(a_build_round, clock, reset, cmd.build, rnd_ff == 6'd0,
      "round counter not cleared")
endmodule
`default_nettype wire

// File: hdl/hash_counter_keystream_encryptor_core.sv
// Counter-mode stream encryptor: each 32-byte keystream chunk is SHA-256 over key, seed,
// a colon and the chunk number in decimal. A start word (op 0) emits 32 bytes: the seed,
// then the watermark added to chunk 0; a data word (op 1) emits one cipher byte. A new chunk
// needs one step per decimal digit (up to 10) and one or two compression blocks on a single
// round unit; input is held off until all results are taken.
`timescale 1ns / 1ps
`default_nettype none
module hash_counter_keystream_encryptor_core #(
   parameter int unsigned KEY_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // plain_byte
   input  wire logic        req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [63:0] key_ff [4];
   logic [5:0]  klen_ff;
   logic [63:0] seed_hi_ff, seed_lo_ff;
   logic        need_chunk, hdr_mode;
   logic [4:0]  out_idx;
   hck_pkg::cmd_type    cmd;
   hck_pkg::status_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff    <= '0;
         seed_hi_ff <= '0;
         seed_lo_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            3'd0: key_ff[0] <= csr_data;
            3'd1: key_ff[1] <= csr_data;
            3'd2: key_ff[2] <= csr_data;
            3'd3: key_ff[3] <= csr_data;
            3'd4: klen_ff <= csr_data[5:0];
            3'd5: seed_hi_ff <= csr_data;
            3'd6: seed_lo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   hck_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .op(req_tuser), .need_chunk,
      .rsp_tready, .rsp_tvalid, .hdr_mode, .out_idx, .sts, .cmd
   );

   hck_dp #(.KEY_BYTES(KEY_BYTES)) u_dp (
      .clock, .reset,
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .key_length(klen_ff), .seed({seed_hi_ff, seed_lo_ff}),
      .req_accept(req_tvalid && req_tready), .op(req_tuser), .plain_byte(req_tdata),
      .hdr_mode, .out_idx, .cmd, .sts, .need_chunk, .out_byte(rsp_tdata)
   );

   assign rsp_tlast = !hdr_mode || (out_idx == 5'd31);
endmodule
`default_nettype wire
